// ===== sv/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants of the page run allocator
//
// Holds the page map geometry, the request function codes, the status codes,
// the sequencer state type and the structures passed to the page map store.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    // Page map geometry.
    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BITS  = $clog2(NUM_PAGES);
    localparam int CNT_BITS   = PAGE_BITS + 1;
    localparam int OWNER_BITS = 8;

    localparam logic [PAGE_BITS-1:0] LAST_PAGE = PAGE_BITS'(NUM_PAGES - 1);

    // Configuration register map.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_FIRST_ALLOC = APB_ADDR_BITS'(0);
    localparam logic [CNT_BITS-1:0] FIRST_ALLOC_RESET = CNT_BITS'(256);

    // Request functions.
    typedef enum logic [1:0] {
        FUNC_ALLOC      = 2'd0,
        FUNC_FREE_RANGE = 2'd1,
        FUNC_FREE_OWNER = 2'd2,
        FUNC_NONE       = 2'd3
    } func_t;

    // Result status codes.
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_OWNER,
        ST_WRITE,
        ST_RESP
    } state_t;

    // One page map entry.
    typedef struct packed {
        logic                  used;
        logic [OWNER_BITS-1:0] owner;
    } page_entry_t;

    // Write request into the page map.
    typedef struct packed {
        logic                 en;
        logic [PAGE_BITS-1:0] addr;
        page_entry_t          data;
    } page_wr_t;

    // Read request into the page map.
    typedef struct packed {
        logic                 en;
        logic [PAGE_BITS-1:0] addr;
    } page_rd_t;

endpackage

`default_nettype wire

// ===== sv/pra_page_map.sv =====
// ----------------------------------------------------------------------------
// pra_page_map: page map store
//
// One entry per physical page holding the used bit and the owner ID. One
// write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_page_map
    import pra_pkg::*;
(
    input  wire logic        aclk,
    input  wire page_wr_t    wr,
    input  wire page_rd_t    rd,
    output page_entry_t      rd_data
);

    page_entry_t mem [NUM_PAGES];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/page_run_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_unit: first-fit allocator of contiguous page runs
//
// Keeps a used bit and an owner per page and serves allocate, free range and
// free by owner requests, with at most one page map read and one write per cycle.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page map; it accepts
// no request meanwhile, though configuration writes are taken. Requests are
// then served one at a time through the single page map port pair. An
// allocate scans from first_allocatable_page and then marks page_count
// pages, a free range clears page_count pages from the start page (pages
// beyond the last one are not visited), and a free by owner reads every
// page. A finished result sits in the output register until taken, while
// the next request can already start.
`default_nettype none

module page_run_allocator_unit
    import pra_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    // Request channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_func,
    input  wire logic [OWNER_BITS-1:0]     s_owner_id,
    input  wire logic [PAGE_BITS-1:0]      s_start_page,
    input  wire logic [CNT_BITS-1:0]       s_page_count,

    // Result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_status,
    output logic [PAGE_BITS-1:0]           m_first_page,

    // Configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]       prdata,
    output logic                           pready
);

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    first_alloc_reg;
    logic [CNT_BITS-1:0]    ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]    run_reg, run_next;
    logic                   dv_reg, dv_next;
    logic [PAGE_BITS-1:0]   dp_reg, dp_next;
    logic [OWNER_BITS-1:0]  owner_reg, owner_next;
    logic                   wr_used_reg, wr_used_next;
    logic                   res_status_reg, res_status_next;
    logic [PAGE_BITS-1:0]   res_first_reg, res_first_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_status_reg, m_status_next;
    logic [PAGE_BITS-1:0]   m_first_reg, m_first_next;

    page_wr_t               map_wr;
    page_rd_t               map_rd;
    page_entry_t            map_q;

    logic                   in_beat;
    logic                   out_free;
    logic [CNT_BITS-1:0]    run_inc;
    logic                   scan_hit;
    logic                   scan_fail;
    logic [PAGE_BITS-1:0]   hit_first;
    logic                   own_match;
    logic                   own_done;
    logic                   write_done;
    logic                   cfg_write;

    // Page map store.
    pra_page_map u_map (
        .aclk    (aclk),
        .wr      (map_wr),
        .rd      (map_rd),
        .rd_data (map_q)
    );

    // Configuration port: always ready, one register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_FIRST_ALLOC);

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_FIRST_ALLOC) begin
            prdata = APB_DATA_BITS'(first_alloc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_alloc_reg <= FIRST_ALLOC_RESET;
        end else if (cfg_write) begin
            first_alloc_reg <= pwdata[CNT_BITS-1:0];
        end
    end

    // Handshakes.
    assign s_ready      = (state_reg == ST_IDLE);
    assign in_beat      = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_first_page = m_first_reg;

    // Scan evaluation of the page whose read data has just arrived.
    assign run_inc    = map_q.used ? '0 : run_reg + CNT_BITS'(1);
    assign scan_hit   = dv_reg && !map_q.used && (run_inc >= cnt_reg);
    assign hit_first  = PAGE_BITS'({1'b0, dp_reg} + CNT_BITS'(1) - cnt_reg);
    assign scan_fail  = !scan_hit &&
                        (dv_reg ? (dp_reg == LAST_PAGE)
                                : (ptr_reg >= CNT_BITS'(NUM_PAGES)));
    assign own_match  = dv_reg && (map_q.owner == owner_reg);
    assign own_done   = dv_reg && (dp_reg == LAST_PAGE);
    assign write_done = (cnt_reg == '0) || (ptr_reg >= CNT_BITS'(NUM_PAGES));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (ptr_reg[PAGE_BITS-1:0] == LAST_PAGE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    case (func_t'(s_func))
                        FUNC_ALLOC: begin
                            state_next = (s_page_count == '0) ? ST_RESP : ST_SCAN;
                        end
                        FUNC_FREE_RANGE: state_next = ST_WRITE;
                        FUNC_FREE_OWNER: state_next = ST_OWNER;
                        default:         state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    state_next = ST_WRITE;
                end else if (scan_fail) begin
                    state_next = ST_RESP;
                end
            end
            ST_OWNER: begin
                if (own_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_WRITE: begin
                if (write_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Datapath and page map accesses.
    always_comb begin
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        dv_next         = 1'b0;
        dp_next         = dp_reg;
        owner_next      = owner_reg;
        wr_used_next    = wr_used_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        map_wr          = '0;
        map_rd          = '0;

        case (state_reg)
            // Clearing pass: one entry per cycle.
            ST_CLEAR: begin
                map_wr.en   = 1'b1;
                map_wr.addr = ptr_reg[PAGE_BITS-1:0];
                ptr_next    = ptr_reg + CNT_BITS'(1);
            end

            // Capture a new request.
            ST_IDLE: begin
                if (in_beat) begin
                    owner_next      = s_owner_id;
                    cnt_next        = s_page_count;
                    run_next        = '0;
                    res_status_next = STATUS_DONE;
                    res_first_next  = '0;
                    wr_used_next    = 1'b0;
                    ptr_next        = '0;
                    case (func_t'(s_func))
                        FUNC_ALLOC: begin
                            ptr_next        = first_alloc_reg;
                            res_status_next = STATUS_NO_SPACE;
                            wr_used_next    = 1'b1;
                        end
                        FUNC_FREE_RANGE: begin
                            ptr_next = {1'b0, s_start_page};
                        end
                        default: begin
                            ptr_next = '0;
                        end
                    endcase
                end
            end

            // First-fit search, one page read per cycle.
            ST_SCAN: begin
                map_rd.en   = !ptr_reg[PAGE_BITS];
                map_rd.addr = ptr_reg[PAGE_BITS-1:0];
                dv_next     = !ptr_reg[PAGE_BITS];
                dp_next     = ptr_reg[PAGE_BITS-1:0];
                ptr_next    = ptr_reg + CNT_BITS'(1);
                if (dv_reg) begin
                    run_next = run_inc;
                end
                if (scan_hit) begin
                    dv_next         = 1'b0;
                    ptr_next        = {1'b0, hit_first};
                    res_status_next = STATUS_DONE;
                    res_first_next  = hit_first;
                end
            end

            // Release by owner: read each page, clear it on a match.
            ST_OWNER: begin
                map_rd.en   = !ptr_reg[PAGE_BITS];
                map_rd.addr = ptr_reg[PAGE_BITS-1:0];
                dv_next     = !ptr_reg[PAGE_BITS];
                dp_next     = ptr_reg[PAGE_BITS-1:0];
                ptr_next    = ptr_reg + CNT_BITS'(1);
                if (own_match) begin
                    map_wr.en   = 1'b1;
                    map_wr.addr = dp_reg;
                end
            end

            // Mark or clear a run of pages.
            ST_WRITE: begin
                if (!write_done) begin
                    map_wr.en         = 1'b1;
                    map_wr.addr       = ptr_reg[PAGE_BITS-1:0];
                    map_wr.data.used  = wr_used_reg;
                    map_wr.data.owner = wr_used_reg ? owner_reg : '0;
                    ptr_next          = ptr_reg + CNT_BITS'(1);
                    cnt_next          = cnt_reg - CNT_BITS'(1);
                end
            end

            // Hand the result to the output register.
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_first_next  = res_first_reg;
                end
            end

            default: begin
                ptr_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        run_reg        <= run_next;
        dp_reg         <= dp_next;
        owner_reg      <= owner_next;
        wr_used_reg    <= wr_used_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
    end

endmodule

`default_nettype wire
